FILE: rtl/lds_pkg.sv
// Shared types, constants and microcode ROM for the lottery draw scheduler.
package lds_pkg;

    localparam int DEF_NUM_ENTRIES = 8;
    localparam int DEF_TICKET_BITS = 16;

    localparam int OPCODE_W  = 2;
    localparam int ENTRY_W   = 3;
    localparam int TICKETS_W = 16;
    localparam int EXCL_W    = 4;
    localparam int RND_W     = 31;
    localparam int RND_CNT_W = $clog2(RND_W);
    localparam int WIN_W     = 3;
    localparam int TOTAL_W   = 19;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 24;

    localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FINISH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DRAW   = 2'd2;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_DECODE    = 4'd1;
    localparam step_t STEP_SUM       = 4'd2;
    localparam step_t STEP_DIV_INIT  = 4'd3;
    localparam step_t STEP_DIV       = 4'd4;
    localparam step_t STEP_WALK_INIT = 4'd5;
    localparam step_t STEP_WALK      = 4'd6;
    localparam step_t STEP_REPORT    = 4'd7;
    localparam step_t STEP_DONE      = 4'd8;
    localparam step_t STEP_WRITE     = 4'd9;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_CAPTURE,
        UOP_CLEAR,
        UOP_SUM,
        UOP_DIV_INIT,
        UOP_DIV,
        UOP_WALK_INIT,
        UOP_WALK,
        UOP_REPORT,
        UOP_WRITE
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_VALID,
        COND_NOT_DRAW,
        COND_NOT_LAST,
        COND_SUM_ZERO,
        COND_BITS_LEFT,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic is_draw;
        logic last_entry;
        logic sum_zero;
        logic bits_left;
        logic out_busy;
    } stat_t;

    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        case (step)
            STEP_IDLE:      w = '{UOP_CAPTURE,   COND_NO_VALID,  STEP_IDLE};
            STEP_DECODE:    w = '{UOP_CLEAR,     COND_NOT_DRAW,  STEP_WRITE};
            STEP_SUM:       w = '{UOP_SUM,       COND_NOT_LAST,  STEP_SUM};
            STEP_DIV_INIT:  w = '{UOP_DIV_INIT,  COND_SUM_ZERO,  STEP_REPORT};
            STEP_DIV:       w = '{UOP_DIV,       COND_BITS_LEFT, STEP_DIV};
            STEP_WALK_INIT: w = '{UOP_WALK_INIT, COND_NEVER,     STEP_IDLE};
            STEP_WALK:      w = '{UOP_WALK,      COND_NOT_LAST,  STEP_WALK};
            STEP_REPORT:    w = '{UOP_REPORT,    COND_OUT_BUSY,  STEP_REPORT};
            STEP_DONE:      w = '{UOP_NOP,       COND_ALWAYS,    STEP_IDLE};
            STEP_WRITE:     w = '{UOP_WRITE,     COND_ALWAYS,    STEP_REPORT};
            default:        w = '{UOP_NOP,       COND_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/lds_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module lds_useq
    import lds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t pc_reg;
    step_t pc_next;
    logic  take;

    assign ctrl = ucode_rom(pc_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:     take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_VALID:  take = !stat.in_valid;
            COND_NOT_DRAW:  take = !stat.is_draw;
            COND_NOT_LAST:  take = !stat.last_entry;
            COND_SUM_ZERO:  take = stat.sum_zero;
            COND_BITS_LEFT: take = stat.bits_left;
            COND_OUT_BUSY:  take = stat.out_busy;
            default:        take = 1'b1;
        endcase
        pc_next = take ? ctrl.target : pc_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: rtl/lds_datapath.sv
// Datapath: ticket table, finished marks, sum, serial modulo, walk and output register.
module lds_datapath
    import lds_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int TICKET_BITS = DEF_TICKET_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_t            ctrl,
    output stat_t            stat,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam int SUM_W = TICKET_BITS + IDX_W;

    logic [OPCODE_W-1:0]    op_reg, op_next;
    logic [ENTRY_W-1:0]     entry_reg, entry_next;
    logic [TICKETS_W-1:0]   tick_in_reg, tick_in_next;
    logic [EXCL_W-1:0]      excl_reg, excl_next;
    logic [RND_W-1:0]       div_reg, div_next;
    logic [TICKET_BITS-1:0] ticket_reg [NUM_ENTRIES];
    logic [TICKET_BITS-1:0] ticket_next [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] fin_reg, fin_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SUM_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       cum_reg, cum_next;
    logic [RND_CNT_W-1:0]   bit_reg, bit_next;
    logic [IDX_W-1:0]       win_reg, win_next;
    logic                   found_reg, found_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    logic                   elig;
    logic [SUM_W-1:0]       cur_tickets;
    logic [SUM_W:0]         trial;
    logic [SUM_W-1:0]       cum_add;
    logic                   accept;
    logic                   entry_ok;

    assign s_axis_tready = (ctrl.uop == UOP_CAPTURE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign elig        = !fin_reg[idx_reg] && (32'(excl_reg) != 32'(idx_reg));
    assign cur_tickets = elig ? SUM_W'(ticket_reg[idx_reg]) : '0;
    assign trial       = {rem_reg, div_reg[RND_W-1]};
    assign cum_add     = cum_reg + cur_tickets;
    assign entry_ok    = 32'(entry_reg) < NUM_ENTRIES;

    always_comb
    begin
        stat.in_valid   = s_axis_tvalid;
        stat.is_draw    = (op_reg == OP_DRAW);
        stat.last_entry = (idx_reg == IDX_W'(NUM_ENTRIES - 1));
        stat.sum_zero   = (sum_reg == '0);
        stat.bits_left  = (bit_reg != '0);
        stat.out_busy   = out_valid_reg && !m_axis_tready;
    end

    always_comb
    begin
        op_next        = op_reg;
        entry_next     = entry_reg;
        tick_in_next   = tick_in_reg;
        excl_next      = excl_reg;
        div_next       = div_reg;
        ticket_next    = ticket_reg;
        fin_next       = fin_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        cum_next       = cum_reg;
        bit_next       = bit_reg;
        win_next       = win_reg;
        found_next     = found_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (ctrl.uop)
            UOP_CAPTURE:
            begin
                if (accept)
                begin
                    op_next      = s_axis_tdata[1:0];
                    entry_next   = s_axis_tdata[4:2];
                    tick_in_next = s_axis_tdata[20:5];
                    excl_next    = s_axis_tdata[24:21];
                    div_next     = s_axis_tdata[55:25];
                end
            end
            UOP_CLEAR:
            begin
                sum_next   = '0;
                idx_next   = '0;
                win_next   = '0;
                found_next = 1'b0;
            end
            UOP_SUM:
            begin
                sum_next = sum_reg + cur_tickets;
                idx_next = idx_reg + IDX_W'(1);
            end
            UOP_DIV_INIT:
            begin
                rem_next = '0;
                bit_next = RND_CNT_W'(RND_W - 1);
            end
            UOP_DIV:
            begin
                if (trial >= {1'b0, sum_reg})
                begin
                    rem_next = SUM_W'(trial - {1'b0, sum_reg});
                end
                else
                begin
                    rem_next = trial[SUM_W-1:0];
                end
                div_next = {div_reg[RND_W-2:0], 1'b0};
                bit_next = bit_reg - RND_CNT_W'(1);
            end
            UOP_WALK_INIT:
            begin
                cum_next = '0;
                idx_next = '0;
            end
            UOP_WALK:
            begin
                cum_next = cum_add;
                if (!found_reg && elig && (rem_reg < cum_add))
                begin
                    win_next   = idx_reg;
                    found_next = 1'b1;
                end
                idx_next = idx_reg + IDX_W'(1);
            end
            UOP_REPORT:
            begin
                if (!stat.out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {&fin_reg, TOTAL_W'(sum_reg), found_reg,
                                      WIN_W'(win_reg)};
                end
            end
            UOP_WRITE:
            begin
                case (op_reg)
                    OP_LOAD:
                    begin
                        if (entry_ok)
                        begin
                            ticket_next[IDX_W'(entry_reg)] = TICKET_BITS'(tick_in_reg);
                        end
                    end
                    OP_FINISH:
                    begin
                        if (entry_ok)
                        begin
                            fin_next[IDX_W'(entry_reg)] = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                ticket_reg[i] <= '0;
            end
            fin_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            ticket_reg    <= ticket_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        entry_reg    <= entry_next;
        tick_in_reg  <= tick_in_next;
        excl_reg     <= excl_next;
        div_reg      <= div_next;
        idx_reg      <= idx_next;
        sum_reg      <= sum_next;
        rem_reg      <= rem_next;
        cum_reg      <= cum_next;
        bit_reg      <= bit_next;
        win_reg      <= win_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: rtl/lottery_draw_scheduler_core.sv
// Top level of the lottery draw scheduler: sequencer, datapath and checks.
//
// Usage: one item enters on the s_axis channel and exactly one result item
// leaves on the m_axis channel for it, in order. Opcode load sets an entry's
// ticket count, finish marks an entry done, draw picks a winner among the
// entries that are not finished and not excluded, with probability in
// proportion to their tickets, using the supplied random value.
// Every result also reports whether all entries are finished.
// From accept to the result on m_axis, load, finish and unused opcodes pass
// the decode, write and report steps; a draw passes decode, a sum walk over
// the table, a bit-serial modulo over the 31-bit random value, a second walk
// that picks the winner, and report. A draw with no eligible tickets goes
// from the sum walk straight to report, skipping the modulo and second walk.
// After a result is loaded, the done step lies before the next item is taken.
// One item is worked on at a time; s_axis_tready is high only between items.
// The result sits in an output register; while m_axis_tready is low the
// block may still take the next item and holds the sequencer at the result
// step until the register frees up.
// Reset clears all ticket counts and finished marks at once.
module lottery_draw_scheduler_core
    import lds_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int TICKET_BITS = DEF_TICKET_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode[1:0], entry_index[4:2], ticket_count[20:5], exclude_index[24:21],
    // random_value[55:25]
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // winner_index[2:0], winner_valid[3], total_tickets[22:4], all_finished[23]
    output logic [OUT_W-1:0] m_axis_tdata
);

    ctrl_t ctrl;
    stat_t stat;

    lds_useq u_useq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    lds_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .TICKET_BITS (TICKET_BITS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again right after accept");

    a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(ctrl.uop == UOP_REPORT))
        else $error("result appeared outside the report step");

    a_no_accept_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !s_axis_tready)
        else $error("input ready in the cycle after a result was loaded");
`endif

endmodule

FILE: test/tb_lottery_draw_scheduler_core.sv
// Self-checking testbench for lottery_draw_scheduler_core: random and directed items, scored in order.
module tb_lottery_draw_scheduler_core;
    import lds_pkg::*;

    localparam int NUM_ENT = DEF_NUM_ENTRIES;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned EXCL_NONE = 8;
    localparam int unsigned RND_MAX = 32'h7FFF_FFFF;
    localparam int unsigned TIX_MAX = 65535;
    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_TAIL = 250;
    localparam int LONG_HOLD = 500;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [RND_W-1:0]     rnd;
        logic [EXCL_W-1:0]    excl;
        logic [TICKETS_W-1:0] tickets;
        logic [ENTRY_W-1:0]   entry;
        logic [OPCODE_W-1:0]  op;
    } draw_req_t;

    typedef struct packed {
        logic               all_fin;
        logic [TOTAL_W-1:0] total;
        logic               win_ok;
        logic [WIN_W-1:0]   winner;
    } grant_t;

    typedef struct {
        bit        drain;
        draw_req_t req;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    logic [TICKETS_W-1:0] ticket_tbl [NUM_ENT];
    logic [NUM_ENT-1:0]   done_mark = '0;

    pending_t feed_q[$];
    grant_t   grant_q[$];
    grant_t   want_g, got_g;
    pending_t nxt_item;
    logic     drv_valid;
    logic [IN_W-1:0] drv_data;
    logic     rdy;

    bit in_taken = 1'b0;
    bit long_hold_done = 1'b0;
    int gap_cnt = 0;
    int hold_cnt = 0;
    int results_seen = 0;
    int calm_after = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    lottery_draw_scheduler_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        for (int i = 0; i < NUM_ENT; i++)
        begin
            ticket_tbl[i] = '0;
        end
    end

    // expected grant for one accepted item; updates the shadow table
    function automatic grant_t predict_grant(input draw_req_t r);
        grant_t g;
        int unsigned sum;
        int unsigned pick;
        int unsigned base;
        bit found;
        g = '0;
        case (r.op)
            OP_LOAD:   ticket_tbl[r.entry] = r.tickets;
            OP_FINISH: done_mark[r.entry] = 1'b1;
            OP_DRAW:
            begin
                sum = 0;
                for (int i = 0; i < NUM_ENT; i++)
                begin
                    if (!done_mark[i] && i != r.excl)
                        sum += ticket_tbl[i];
                end
                if (sum != 0)
                begin
                    pick = r.rnd % sum;
                    base = 0;
                    found = 1'b0;
                    for (int i = 0; i < NUM_ENT; i++)
                    begin
                        if (!found && !done_mark[i] && i != r.excl)
                        begin
                            if (pick >= base && pick < base + ticket_tbl[i])
                            begin
                                g.winner = i[WIN_W-1:0];
                                g.win_ok = 1'b1;
                                found = 1'b1;
                            end
                            base += ticket_tbl[i];
                        end
                    end
                    g.total = sum[TOTAL_W-1:0];
                end
            end
            default: ;
        endcase
        g.all_fin = &done_mark;
        return g;
    endfunction

    task automatic check_field(input string what, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            if (err_cnt < 10)
                $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
            err_cnt++;
        end
    endtask

    task automatic queue_item(input logic [OPCODE_W-1:0] op, input int unsigned entry,
                              input int unsigned tix, input int unsigned excl,
                              input int unsigned rnd, input bit drain = 1'b0);
        pending_t p;
        p.drain = drain;
        p.req.op = op;
        p.req.entry = entry[ENTRY_W-1:0];
        p.req.tickets = tix[TICKETS_W-1:0];
        p.req.excl = excl[EXCL_W-1:0];
        p.req.rnd = rnd[RND_W-1:0];
        feed_q.push_back(p);
    endtask

    // scoreboard: check results, then predict newly accepted items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_g = m_axis_tdata;
                if (grant_q.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("unexpected result item: %h", m_axis_tdata);
                    err_cnt++;
                end
                else
                begin
                    want_g = grant_q.pop_front();
                    check_field("winner_index", want_g.winner, got_g.winner);
                    check_field("winner_valid", want_g.win_ok, got_g.win_ok);
                    check_field("total_tickets", want_g.total, got_g.total);
                    check_field("all_finished", want_g.all_fin, got_g.all_fin);
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                grant_q.push_back(predict_grant(s_axis_tdata));
                in_taken = 1'b1;
            end
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            drv_valid = s_axis_tvalid;
            drv_data = s_axis_tdata;
            if (!s_axis_tvalid || in_taken)
            begin
                in_taken = 1'b0;
                drv_valid = 1'b0;
                if (gap_cnt > 0)
                    gap_cnt--;
                else if (feed_q.size() > QUIET_TAIL && (feed_q.size() / 150) % 2 == 0
                         && $urandom_range(0, 7) == 0)
                    gap_cnt = $urandom_range(1, 12) - 1;
                else if (feed_q.size() > 0 && (!feed_q[0].drain || grant_q.size() == 0))
                begin
                    nxt_item = feed_q.pop_front();
                    drv_valid = 1'b1;
                    drv_data = nxt_item.req;
                end
            end
            s_axis_tvalid <= drv_valid;
            s_axis_tdata <= drv_data;
        end
    end

    // result sink with stall bursts and one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rdy = 1'b0;
            end
            else if (!long_hold_done && results_seen >= 400)
            begin
                long_hold_done = 1'b1;
                hold_cnt = LONG_HOLD - 1;
                rdy = 1'b0;
            end
            else if (results_seen < calm_after && (results_seen / 150) % 2 == 0
                     && $urandom_range(0, 7) == 0)
            begin
                hold_cnt = $urandom_range(1, 12) - 1;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            m_axis_tready <= rdy;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("lottery_draw_scheduler_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned op_sel;
        int unsigned tix;
        int unsigned excl;
        int unsigned rnd;
        logic [OPCODE_W-1:0] op;
        int unsigned entry;

        // empty table, then edge values and range boundaries
        queue_item(OP_DRAW, 0, 0, EXCL_NONE, RND_MAX);
        queue_item(OP_LOAD, 0, TIX_MAX, EXCL_NONE, 0);
        queue_item(OP_LOAD, 7, 1, EXCL_NONE, 0);
        queue_item(OP_LOAD, 3, 0, EXCL_NONE, 0);
        queue_item(OP_DRAW, 0, 0, EXCL_NONE, 0);
        queue_item(OP_DRAW, 0, 0, EXCL_NONE, TIX_MAX);
        queue_item(OP_DRAW, 0, 0, 0, RND_MAX);
        queue_item(OP_DRAW, 0, 0, 7, 12345);
        queue_item(OP_DRAW, 0, 0, 15, RND_MAX);
        queue_item(OP_UNUSED, 7, TIX_MAX, 15, RND_MAX);
        queue_item(OP_LOAD, 1, 1, 0, 0);
        queue_item(OP_LOAD, 2, 2, 0, 0);
        queue_item(OP_LOAD, 4, 4, 0, 0);
        queue_item(OP_LOAD, 5, 5, 0, 0);
        queue_item(OP_LOAD, 6, 6, 0, 0);
        queue_item(OP_DRAW, 0, 0, 3, TIX_MAX + 1);
        queue_item(OP_FINISH, 0, 0, 0, 0);
        queue_item(OP_FINISH, 0, 0, 0, 0);
        queue_item(OP_DRAW, 0, 0, EXCL_NONE, 0);
        queue_item(OP_DRAW, 0, 0, 1, 2);
        queue_item(OP_LOAD, 0, 7, 0, 0);
        queue_item(OP_DRAW, 0, 0, 9, 17);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            op_sel = $urandom_range(0, 99);
            entry = $urandom_range(0, 7);
            case ($urandom_range(0, 4))
                0: tix = 0;
                1: tix = $urandom_range(1, 8);
                2: tix = $urandom_range(1, 300);
                3: tix = TIX_MAX;
                default: tix = $urandom();
            endcase
            case ($urandom_range(0, 3))
                0: excl = EXCL_NONE;
                1: excl = $urandom_range(9, 15);
                default: excl = $urandom_range(0, 7);
            endcase
            case ($urandom_range(0, 3))
                0: rnd = $urandom_range(0, 400);
                1: rnd = RND_MAX;
                default: rnd = $urandom();
            endcase
            if (op_sel < 28)
                op = OP_LOAD;
            else if (op_sel < 30)
            begin
                op = OP_FINISH;
                entry = $urandom_range(1, 2);
            end
            else if (op_sel < 33)
                op = OP_UNUSED;
            else
                op = OP_DRAW;
            queue_item(op, entry, tix, excl, rnd, n == RANDOM_ITEMS / 2);
        end

        // retire every entry; the table ends fully finished
        queue_item(OP_DRAW, 0, 0, EXCL_NONE, $urandom(), 1'b1);
        for (int e = 3; e < NUM_ENT; e++)
        begin
            queue_item(OP_LOAD, e, $urandom_range(1, 1000), 0, 0);
            queue_item(OP_FINISH, e, 0, 0, 0);
            queue_item(OP_DRAW, 0, 0, EXCL_NONE, $urandom());
        end
        queue_item(OP_FINISH, 1, 0, 0, 0);
        queue_item(OP_FINISH, 2, 0, 0, 0);
        queue_item(OP_DRAW, 0, 0, EXCL_NONE, RND_MAX);
        queue_item(OP_LOAD, 4, TIX_MAX, 0, 0);
        queue_item(OP_UNUSED, 0, 0, 0, 0);
        queue_item(OP_DRAW, 0, 0, 2, 5);

        calm_after = feed_q.size() - QUIET_TAIL;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (feed_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("lottery_draw_scheduler_core regression: pass");
        else
            $display("lottery_draw_scheduler_core regression: fail");
        $finish;
    end

endmodule
